>>> hdl/dqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types and constants for the double-ended queue with reverse.
// ----------------------------------------------------------------------------
package dqr_pkg;

    localparam int DEPTH      = 16;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 3;
    localparam int WORD_W     = 64;
    localparam int CNT_OUT_W  = 5;
    localparam int STAT_W     = 2;

    // command queue between front and back
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY  = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_REV,
        OP_NOP
    } t_kind;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] data_in;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0]    front_word;
        logic [WORD_W-1:0]    back_word;
        logic [CNT_OUT_W-1:0] entry_count_out;
        logic                 is_empty;
        logic                 is_full;
        logic [STAT_W-1:0]    status;
    } t_out;

    // classified command handed from front to back
    typedef struct packed {
        t_kind             kind;
        logic              at_front;
        logic [WORD_W-1:0] data;
    } t_op;

endpackage

>>> hdl/deque_with_reverse.sv
`timescale 1ns / 1ps
// A transferred command passes the front command queue and the back unit's execute,
// registered store read and result load steps before its result shows (empty low).
// The back unit runs one command at a time; a 2-entry queue absorbs input bursts.
// Reset (i_rst_n low, synchronous) empties the queue, clears the reverse flag and
// drops any pending commands and results; the word store itself is not cleared.
// ----------------------------------------------------------------------------
// deque_with_reverse
// Bounded double-ended queue of 64-bit words with constant-time reverse.
// ----------------------------------------------------------------------------
module deque_with_reverse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  dqr_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output dqr_pkg::t_out o_result
);
    import dqr_pkg::*;

    t_op  w_op;
    logic w_op_valid;
    logic w_op_take;

    dqr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_op_valid (w_op_valid),
        .i_op_take  (w_op_take),
        .o_op       (w_op)
    );

    dqr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .o_op_take  (w_op_take),
        .i_op       (w_op),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

endmodule

>>> hdl/dqr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_front
// Accepts commands, classifies them and buffers them in a short queue.
// ----------------------------------------------------------------------------
module dqr_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  dqr_pkg::t_in i_item,
    output logic         o_op_valid,
    input  logic         i_op_take,
    output dqr_pkg::t_op o_op
);
    import dqr_pkg::*;

    function automatic t_op classify(input t_in item);
        t_op op;
        op.data     = item.data_in;
        op.at_front = 1'b0;
        op.kind     = OP_NOP;
        unique case (item.cmd)
            CMD_PUSH_FRONT: begin op.kind = OP_PUSH; op.at_front = 1'b1; end
            CMD_PUSH_BACK:  begin op.kind = OP_PUSH; op.at_front = 1'b0; end
            CMD_POP_FRONT:  begin op.kind = OP_POP;  op.at_front = 1'b1; end
            CMD_POP_BACK:   begin op.kind = OP_POP;  op.at_front = 1'b0; end
            CMD_REVERSE:    op.kind = OP_REV;
            default:        op.kind = OP_NOP;  // peek and unused codes
        endcase
        return op;
    endfunction

    t_op               r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full     = (r_cnt == QCNT_W'(QDEPTH));
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_q[r_rd_ptr];
    assign w_wr       = i_push && !o_full;
    assign w_rd       = o_op_valid && i_op_take;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= classify(i_item);
        end
    end

endmodule

>>> hdl/dqr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_back
// Executes classified commands on the ring store and builds the result.
// ----------------------------------------------------------------------------
module dqr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    output logic          o_op_take,
    input  dqr_pkg::t_op  i_op,
    output logic          o_empty,
    input  logic          i_pop,
    output dqr_pkg::t_out o_result
);
    import dqr_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    localparam logic [1:0] S_EXEC = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    logic [WORD_W-1:0] r_mem [DEPTH];

    logic [1:0]        r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_rev, n_rev;
    logic [STAT_W-1:0] r_status, n_status;
    logic [WORD_W-1:0] r_rd_head, r_rd_tail;
    t_out              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              w_we;
    logic [PTR_W-1:0]  w_waddr;
    logic [PTR_W-1:0]  w_tail_addr;
    logic              w_at_head;
    logic              w_out_load;
    logic [WORD_W-1:0] w_head_word, w_tail_word;

    assign w_tail_addr = ring_add(r_head, r_count - 1'b1);
    assign w_at_head   = i_op.at_front ^ r_rev;
    assign o_op_take   = (r_state == S_EXEC);
    assign w_out_load  = (r_state == S_EMIT) && (!r_out_valid || i_pop);
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = ring_add(r_head, r_count);
        unique case (r_state)
            S_EXEC: begin
                if (i_op_valid) begin
                    n_status = ST_OK;
                    n_state  = S_READ;
                    unique case (i_op.kind)
                        OP_PUSH: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_PUSH_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                                if (w_at_head) begin
                                    n_head  = (r_head == '0) ? PTR_W'(DEPTH - 1)
                                                             : r_head - 1'b1;
                                    w_waddr = n_head;
                                end
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_POP_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                                if (w_at_head) begin
                                    n_head = ring_add(r_head, CNT_W'(1));
                                end
                            end
                        end
                        OP_REV:  n_rev = !r_rev;
                        OP_NOP:  ;
                        default: ;
                    endcase
                end
            end
            S_READ:  n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = S_EXEC;
                end
            end
            default: n_state = S_EXEC;
        endcase
    end

    // empty queue reads zero on both ends
    assign w_head_word = (r_count == '0) ? '0 : r_rd_head;
    assign w_tail_word = (r_count == '0) ? '0 : r_rd_tail;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        if (w_out_load) begin
            n_out_valid           = 1'b1;
            n_out.front_word      = r_rev ? w_tail_word : w_head_word;
            n_out.back_word       = r_rev ? w_head_word : w_tail_word;
            n_out.entry_count_out = CNT_OUT_W'(r_count);
            n_out.is_empty        = (r_count == '0);
            n_out.is_full         = (r_count == CNT_W'(DEPTH));
            n_out.status          = r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXEC;
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_op.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_head <= r_mem[r_head];
            r_rd_tail <= r_mem[w_tail_addr];
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_status == ST_PUSH_FULL) |-> r_count == CNT_W'(DEPTH))
        else $error("push dropped while not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_status == ST_POP_EMPTY) |-> r_count == '0)
        else $error("pop ignored while not empty");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && r_state == S_EXEC))
        else $error("result load did not take effect");
`endif

endmodule

>>> test/dqr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_checker
// Watches the command and result channels of the deque and keeps its own copy
// of the ring store, head, count and direction. Each accepted command yields
// one predicted result; each accepted result is compared with the oldest one.
// ----------------------------------------------------------------------------
module dqr_checker
    import dqr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_full,
    input  t_in  i_item,
    input  logic i_empty,
    input  logic i_pop,
    input  t_out i_result,
    output int   o_fail_count,
    output int   o_pending
);

    logic [WORD_W-1:0] ring_word [DEPTH];
    logic [PTR_W-1:0]  ring_head;
    logic [CNT_W-1:0]  ring_fill;
    logic              ring_flipped;

    t_out due_results[$];
    int   fail_total  = 0;
    int   shown_total = 0;
    int   due_total   = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_total;

    task automatic clear_deque();
        for (int k = 0; k < DEPTH; k++) begin
            ring_word[k] = '0;
        end
        ring_head    = '0;
        ring_fill    = '0;
        ring_flipped = 1'b0;
    endtask

    // apply one command to the shadow deque and report the state after it
    task automatic advance_deque(input t_in cmd_in, output t_out res);
        logic [STAT_W-1:0] st;
        logic              front_is_head;
        logic              at_head;
        logic [WORD_W-1:0] head_w;
        logic [WORD_W-1:0] tail_w;
        logic [PTR_W-1:0]  tail_idx;
        st            = ST_OK;
        front_is_head = !ring_flipped;
        at_head       = (cmd_in.cmd == CMD_PUSH_FRONT || cmd_in.cmd == CMD_POP_FRONT)
                        ? front_is_head : !front_is_head;
        case (cmd_in.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (ring_fill >= DEPTH) begin
                    st = ST_PUSH_FULL;
                end else begin
                    if (at_head) begin
                        ring_head            = ring_head - 1'b1;
                        ring_word[ring_head] = cmd_in.data_in;
                    end else begin
                        ring_word[ring_head + ring_fill[PTR_W-1:0]] = cmd_in.data_in;
                    end
                    ring_fill = ring_fill + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (ring_fill == 0) begin
                    st = ST_POP_EMPTY;
                end else begin
                    if (at_head) ring_head = ring_head + 1'b1;
                    ring_fill = ring_fill - 1'b1;
                end
            end
            CMD_REVERSE: begin
                ring_flipped = !ring_flipped;
            end
            default: ;
        endcase

        head_w = '0;
        tail_w = '0;
        if (ring_fill != 0) begin
            // a full ring wraps to head - 1, which the pointer width handles
            tail_idx = ring_head + ring_fill[PTR_W-1:0] - 1'b1;
            head_w   = ring_word[ring_head];
            tail_w   = ring_word[tail_idx];
        end
        res.front_word      = ring_flipped ? tail_w : head_w;
        res.back_word       = ring_flipped ? head_w : tail_w;
        res.entry_count_out = CNT_OUT_W'(ring_fill);
        res.is_empty        = (ring_fill == 0);
        res.is_full         = (ring_fill >= DEPTH);
        res.status          = st;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            clear_deque();
            due_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                got = i_result;
                if (due_results.size() == 0) begin
                    fail_total++;
                    if (shown_total < 10) begin
                        shown_total++;
                        $display("%0t: result transfer with nothing expected", $realtime);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (got.front_word !== want.front_word
                        || got.back_word !== want.back_word
                        || got.entry_count_out !== want.entry_count_out
                        || got.is_empty !== want.is_empty
                        || got.is_full !== want.is_full
                        || got.status !== want.status) begin
                        fail_total++;
                        if (shown_total < 10) begin
                            shown_total++;
                            $display("%0t: mismatch exp front=%h back=%h cnt=%0d e=%b f=%b st=%0d",
                                     $realtime, want.front_word, want.back_word,
                                     want.entry_count_out, want.is_empty, want.is_full,
                                     want.status);
                            $display("%0t:          got front=%h back=%h cnt=%0d e=%b f=%b st=%0d",
                                     $realtime, got.front_word, got.back_word,
                                     got.entry_count_out, got.is_empty, got.is_full,
                                     got.status);
                        end
                    end
                end
            end
            if (i_push && !i_full) begin
                advance_deque(i_item, want);
                due_results.push_back(want);
            end
        end
        due_total = due_results.size();
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the deque with reverse: a directed pass over the empty, full,
// reverse and unused-code cases, then phases of fill-heavy, drain-heavy and
// mixed random commands with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
    import dqr_pkg::*;

    // unused command codes, handled as peek
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int RANDOM_CMDS = 1900;
    localparam int CALM_TAIL   = 200;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_item;
    logic empty;
    logic pop;
    t_out o_result;
    int   fail_count;
    int   pending;

    int   idle_pct;
    int   pop_hold;

    deque_with_reverse dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    dqr_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: pop held low in random bursts while idling is on
    initial begin
        pop      = 1'b0;
        pop_hold = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (pop_hold > 0) begin
                pop      <= 1'b0;
                pop_hold = pop_hold - 1;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                pop      <= 1'b0;
                pop_hold = $urandom_range(1, 19) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // one command transfer; starts and ends at a falling edge
    task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [WORD_W-1:0] word);
        t_in it;
        it.cmd     = code;
        it.data_in = word;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // fill mode leans to pushes, drain mode to pops, mixed is balanced
    function automatic logic [CMD_W-1:0] rand_cmd(input int mode);
        int r;
        int push_cut;
        r        = $urandom_range(0, 99);
        push_cut = (mode == 0) ? 74 : (mode == 1) ? 38 : 56;
        if (r < 6)         return CMD_REVERSE;
        else if (r < 10)   return CMD_PEEK;
        else if (r < 12)   return $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
        else if (r < push_cut)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else
            return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    endfunction

    initial begin
        int mode;
        int phase_left;
        i_rst_n  = 1'b0;
        push     = 1'b0;
        i_item   = '0;
        idle_pct = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue corners, then fill to full and push past it
        send_cmd(CMD_PEEK, '0);
        send_cmd(CMD_POP_FRONT, '1);
        send_cmd(CMD_POP_BACK, '1);
        send_cmd(CMD_REVERSE, '0);
        send_cmd(CMD_PUSH_FRONT, '1);
        send_cmd(CMD_PUSH_BACK, '0);
        send_cmd(CMD_SPARE_A, '1);
        send_cmd(CMD_SPARE_B, '1);
        send_cmd(CMD_REVERSE, '0);
        for (int k = 0; k < DEPTH - 2; k++) begin
            send_cmd(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                     k[1] ? 64'hAAAA_AAAA_AAAA_AAAA ^ k : 64'h5555_5555_5555_5555 ^ k);
        end
        send_cmd(CMD_PUSH_FRONT, 64'hDEAD_0000_0000_0001);
        send_cmd(CMD_PUSH_BACK, 64'hDEAD_0000_0000_0002);
        send_cmd(CMD_POP_FRONT, '0);
        send_cmd(CMD_POP_BACK, '0);
        wait_drained();
        @(negedge i_clk);

        phase_left = 0;
        mode       = 2;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(30, 80);
                mode       = $urandom_range(0, 2);
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 5;
                    default: idle_pct = 25;
                endcase
            end
            phase_left = phase_left - 1;
            if (n >= RANDOM_CMDS - CALM_TAIL) idle_pct = 0;
            if (n == RANDOM_CMDS / 2) begin
                wait_drained();
                @(negedge i_clk);
            end
            send_cmd(rand_cmd(mode), rand_word());
        end

        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/dqr_pkg.sv
hdl/dqr_front.sv
hdl/dqr_back.sv
hdl/deque_with_reverse.sv
test/dqr_checker.sv
test/tb.sv
